/* rtl/core/bfx_pkg.sv */
// shared types, constants and register codes for the binary frame extractor
package bfx_pkg;

  // fixed frame geometry
  localparam int HOLD_BYTES = 10;
  localparam int CRC_BYTES  = 4;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 4;
  localparam int SEARCH_POS = HOLD_BYTES - 2;
  localparam int POS_W      = 3;
  localparam int LEN_LO_POS = 8;
  localparam int LEN_HI_POS = 9;

  // arithmetic widths
  localparam int LIMIT_W = 14;
  localparam int REM_W   = 14;
  localparam int TOTAL_W = 17;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_FIRST    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_SECOND   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_THIRD    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADER_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_LIMIT  = 3'd4;

  // register reset values
  localparam logic [BYTE_W-1:0]  SYNC_FIRST_RST    = 8'd170;
  localparam logic [BYTE_W-1:0]  SYNC_SECOND_RST   = 8'd68;
  localparam logic [BYTE_W-1:0]  SYNC_THIRD_RST    = 8'd18;
  localparam logic [BYTE_W-1:0]  HEADER_LENGTH_RST = 8'd28;
  localparam logic [LIMIT_W-1:0] LENGTH_LIMIT_RST  = 14'd16380;

  // header hold, byte 0 in the low bits
  typedef logic [HOLD_BYTES-1:0][BYTE_W-1:0] hold_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  sync_first;
    logic [BYTE_W-1:0]  sync_second;
    logic [BYTE_W-1:0]  sync_third;
    logic [BYTE_W-1:0]  header_length;
    logic [LIMIT_W-1:0] length_limit;
  } cfg_t;

  // outcome of one pass of the sync search
  typedef struct packed {
    logic             err;
    logic             start;
    logic [REM_W-1:0] remaining;
  } hunt_res_t;

  // one result word
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic              err;
  } result_t;

endpackage

/* rtl/core/bfx_hunt.sv */
// sync search, realignment and header length check over the header hold
module bfx_hunt import bfx_pkg::*; (
  input  hold_t            hold_in,
  input  logic [CNT_W-1:0] count_in,
  input  cfg_t             cfg,
  output hold_t            hold_out,
  output logic [CNT_W-1:0] count_out,
  output hunt_res_t        res
);

  logic [SEARCH_POS-1:0] match;
  logic                  found;
  logic [POS_W-1:0]      pos;
  logic [BYTE_W-1:0]     hlen;
  logic [TOTAL_W-1:0]    total;
  logic [CNT_W-1:0]      idx_last;
  logic [CNT_W-1:0]      idx_prev;

  // sync compare at every start position inside the held bytes
  always_comb begin
    for (int i = 0; i < SEARCH_POS; i++) begin
      match[i] = (CNT_W'(i + 2) < count_in) &&
                 (hold_in[i]     == cfg.sync_first) &&
                 (hold_in[i + 1] == cfg.sync_second) &&
                 (hold_in[i + 2] == cfg.sync_third);
    end
  end

  // earliest match wins
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = SEARCH_POS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        pos   = POS_W'(i);
      end
    end
  end

  // length sum, short header lengths raised to the hold size
  assign hlen  = (cfg.header_length < BYTE_W'(HOLD_BYTES)) ? BYTE_W'(HOLD_BYTES)
                                                           : cfg.header_length;
  assign total = TOTAL_W'({hold_in[LEN_HI_POS], hold_in[LEN_LO_POS]}) + TOTAL_W'(hlen);

  assign idx_last = count_in - CNT_W'(1);
  assign idx_prev = count_in - CNT_W'(2);

  // next hold contents and frame decision
  always_comb begin
    hold_out      = hold_in;
    count_out     = count_in;
    res.err       = 1'b0;
    res.start     = 1'b0;
    res.remaining = REM_W'(total + TOTAL_W'(CRC_BYTES) - TOTAL_W'(HOLD_BYTES));
    if (count_in >= CNT_W'(3)) begin
      if (!found) begin
        // keep the last two bytes, they may begin a sync pattern
        hold_out[0] = hold_in[idx_prev];
        hold_out[1] = hold_in[idx_last];
        count_out   = CNT_W'(2);
      end else if (pos != '0) begin
        hold_out  = hold_in >> {pos, 3'b000};
        count_out = count_in - CNT_W'(pos);
      end else if (count_in == CNT_W'(HOLD_BYTES)) begin
        if (total > TOTAL_W'(cfg.length_limit)) begin
          // overlength: drop the first byte and search again
          res.err   = 1'b1;
          hold_out  = hold_in >> BYTE_W;
          count_out = CNT_W'(HOLD_BYTES - 1);
        end else begin
          res.start = 1'b1;
          count_out = '0;
        end
      end
    end
  end

endmodule

/* rtl/core/bfx_result_fifo.sv */
// two-word result queue between the framer and the output channel
module bfx_result_fifo import bfx_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  // word storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/binary_receiver_frame_extractor.sv */
// top level of the binary log frame extractor
//
// Input channel in_valid/in_ready/in_byte takes one received byte per word.
// Output channel out_valid/out_ready carries out_byte with frame_first,
// frame_last and overlength_error; words come from a two-word result queue.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// sync bytes, header length and length limit; cfg_ready is always high.
// Hunting: each byte enters the ten-byte header hold and the sync search
// runs in the same cycle. A forwarded frame byte or an error word is
// written into the result queue in the cycle its input word is accepted.
// Inside a frame one byte is taken per cycle as long as the output drains.
// When the tenth header byte passes the length check, the ten held bytes
// are queued one per cycle while the queue has room, and input is stalled
// until all of them are queued. An overlength error stalls input while the
// nine remaining held bytes are searched again.
// When the receiver stalls, the queue fills and in_ready drops after two
// waiting words. Reset empties the hold and queue, returns to hunting and
// restores the register defaults.
module binary_receiver_frame_extractor import bfx_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_W-1:0]      in_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   frame_first,
  output logic                   frame_last,
  output logic                   overlength_error,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t             cfg;
  hold_t            hold;
  logic [CNT_W-1:0] held_count;
  logic             in_frame;
  logic [REM_W-1:0] remaining;
  logic             rescan;
  logic [CNT_W-1:0] drain;

  hold_t            hunt_hold_in;
  logic [CNT_W-1:0] hunt_count_in;
  hold_t            hunt_hold;
  logic [CNT_W-1:0] hunt_count;
  hunt_res_t        hunt_res;

  logic             in_acc;
  logic             hunt_go;
  logic             fifo_full;
  logic             push;
  result_t          push_data;
  result_t          head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !rescan && (drain == '0) && !fifo_full;
  assign in_acc    = in_valid && in_ready;
  assign hunt_go   = rescan || (in_acc && !in_frame);

  // hold contents seen by the search: new byte appended, or as is on rescan
  always_comb begin
    hunt_hold_in  = hold;
    hunt_count_in = held_count;
    if (!rescan && (held_count < CNT_W'(HOLD_BYTES))) begin
      hunt_hold_in[held_count] = in_byte;
      hunt_count_in            = held_count + CNT_W'(1);
    end
  end

  bfx_hunt u_hunt (
    .hold_in   (hunt_hold_in),
    .count_in  (hunt_count_in),
    .cfg       (cfg),
    .hold_out  (hunt_hold),
    .count_out (hunt_count),
    .res       (hunt_res)
  );

  // result word selection
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if ((drain != '0) && !fifo_full) begin
      push            = 1'b1;
      push_data.data  = hold[0];
      push_data.first = (drain == CNT_W'(HOLD_BYTES));
    end else if (in_acc && in_frame) begin
      push           = 1'b1;
      push_data.data = in_byte;
      push_data.last = (remaining == REM_W'(1));
    end else if (hunt_go && hunt_res.err) begin
      push          = 1'b1;
      push_data.err = 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first    <= SYNC_FIRST_RST;
      cfg.sync_second   <= SYNC_SECOND_RST;
      cfg.sync_third    <= SYNC_THIRD_RST;
      cfg.header_length <= HEADER_LENGTH_RST;
      cfg.length_limit  <= LENGTH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_FIRST:    cfg.sync_first    <= cfg_data[BYTE_W-1:0];
        REG_SYNC_SECOND:   cfg.sync_second   <= cfg_data[BYTE_W-1:0];
        REG_SYNC_THIRD:    cfg.sync_third    <= cfg_data[BYTE_W-1:0];
        REG_HEADER_LENGTH: cfg.header_length <= cfg_data[BYTE_W-1:0];
        REG_LENGTH_LIMIT:  cfg.length_limit  <= cfg_data[LIMIT_W-1:0];
        default:           cfg.length_limit  <= cfg.length_limit;
      endcase
    end
  end

  // header hold, shifted out while the header drains
  always_ff @(posedge clk) begin
    if (hunt_go) begin
      hold <= hunt_hold;
    end else if ((drain != '0) && !fifo_full) begin
      hold <= hold >> BYTE_W;
    end
  end

  // framing control
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      in_frame   <= 1'b0;
      remaining  <= '0;
      rescan     <= 1'b0;
      drain      <= '0;
    end else begin
      if (hunt_go) begin
        held_count <= hunt_count;
        rescan     <= hunt_res.err;
        if (hunt_res.start) begin
          in_frame  <= 1'b1;
          remaining <= hunt_res.remaining;
          drain     <= CNT_W'(HOLD_BYTES);
        end
      end
      if ((drain != '0) && !fifo_full) begin
        drain <= drain - CNT_W'(1);
      end
      if (in_acc && in_frame) begin
        remaining <= remaining - REM_W'(1);
        if (remaining == REM_W'(1)) begin
          in_frame <= 1'b0;
        end
      end
    end
  end

  bfx_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_byte         = head.data;
  assign frame_first      = head.first;
  assign frame_last       = head.last;
  assign overlength_error = head.err;

endmodule

/* tb/sv/testbench.sv */
// self-checking bench for the binary receiver frame extractor
`timescale 1ns / 1ps

module testbench;
  import bfx_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 12;
  localparam int SETTLE_WAIT  = 16;
  localparam int MAX_REPORTED = 10;

  // index past the register list, must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;

  // how a stimulus row is checked
  typedef enum {
    ROW_CFG,
    ROW_QUIET,
    ROW_PREDICT,
    ROW_ERROR,
    ROW_FWD,
    ROW_LAST
  } row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [BYTE_W-1:0]       value;
    logic [CFG_INDEX_W-1:0]  index;
    logic [CFG_DATA_W-1:0]   data;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [BYTE_W-1:0]      in_byte;
  logic                   out_valid;
  logic                   out_ready = 1'b1;
  logic [BYTE_W-1:0]      out_byte;
  logic                   frame_first;
  logic                   frame_last;
  logic                   overlength_error;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  binary_receiver_frame_extractor dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .frame_first      (frame_first),
    .frame_last       (frame_last),
    .overlength_error (overlength_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the extractor state and registers
  logic [BYTE_W-1:0]  hold_copy [HOLD_BYTES];
  int                 held_n;
  int                 frame_left;
  bit                 framing;
  logic [BYTE_W-1:0]  sync_pat [3];
  logic [BYTE_W-1:0]  hdr_len;
  logic [LIMIT_W-1:0] len_limit;

  result_t   step_words [$];
  result_t   awaited_words [$];
  row_kind_e row_checks [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  row_t      directed_rows [22];

  // search the hold for the sync pattern, check the length, emit header
  function automatic void resync_hold();
    int pos;
    int eff;
    int total;
    while (1'b1) begin
      if (held_n < 3) return;
      pos = -1;
      for (int i = 0; i + 2 < held_n; i++) begin
        if (hold_copy[i] == sync_pat[0] && hold_copy[i + 1] == sync_pat[1] &&
            hold_copy[i + 2] == sync_pat[2]) begin
          pos = i;
          break;
        end
      end
      // no pattern: only the last two bytes can still start one
      if (pos < 0) begin
        hold_copy[0] = hold_copy[held_n - 2];
        hold_copy[1] = hold_copy[held_n - 1];
        held_n = 2;
        return;
      end
      if (pos > 0) begin
        held_n -= pos;
        for (int k = 0; k < held_n; k++) hold_copy[k] = hold_copy[k + pos];
      end
      if (held_n < HOLD_BYTES) return;
      eff = (hdr_len < HOLD_BYTES) ? HOLD_BYTES : int'(hdr_len);
      total = int'({hold_copy[LEN_HI_POS], hold_copy[LEN_LO_POS]}) + eff;
      if (total > int'(len_limit)) begin
        // overlength: drop the first byte and hunt again
        step_words.push_back('{data: '0, first: 1'b0, last: 1'b0, err: 1'b1});
        held_n--;
        for (int k = 0; k < held_n; k++) hold_copy[k] = hold_copy[k + 1];
      end else begin
        for (int k = 0; k < HOLD_BYTES; k++)
          step_words.push_back('{data: hold_copy[k], first: (k == 0), last: 1'b0,
                                 err: 1'b0});
        frame_left = total + CRC_BYTES - HOLD_BYTES;
        framing = 1'b1;
        held_n = 0;
        return;
      end
    end
  endfunction

  // expected output words for one received byte
  function automatic void extract_byte(input logic [BYTE_W-1:0] b);
    step_words.delete();
    if (framing) begin
      if (frame_left > 0) frame_left--;
      step_words.push_back('{data: b, first: 1'b0, last: (frame_left == 0), err: 1'b0});
      if (frame_left == 0) framing = 1'b0;
      return;
    end
    if (held_n < HOLD_BYTES) begin
      hold_copy[held_n] = b;
      held_n++;
    end
    resync_hold();
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_SYNC_FIRST:    sync_pat[0] = value[BYTE_W-1:0];
      REG_SYNC_SECOND:   sync_pat[1] = value[BYTE_W-1:0];
      REG_SYNC_THIRD:    sync_pat[2] = value[BYTE_W-1:0];
      REG_HEADER_LENGTH: hdr_len = value[BYTE_W-1:0];
      REG_LENGTH_LIMIT:  len_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void flag_mismatch(input string what, input result_t want,
                                        input result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTED)
      $display("%0t %s: expected %02h f%0b l%0b e%0b, got %02h f%0b l%0b e%0b",
               $realtime, what, want.data, want.first, want.last, want.err,
               got.data, got.first, got.last, got.err);
  endfunction

  // predict on accepted bytes, check each accepted output word
  always @(posedge clk) begin : check_words
    result_t   got;
    result_t   want;
    row_kind_e kind;
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        extract_byte(in_byte);
        kind = row_checks.pop_front();
        case (kind)
          ROW_PREDICT: foreach (step_words[i]) awaited_words.push_back(step_words[i]);
          ROW_ERROR:   awaited_words.push_back('{data: '0, first: 1'b0, last: 1'b0,
                                                 err: 1'b1});
          ROW_FWD:     awaited_words.push_back('{data: in_byte, first: 1'b0, last: 1'b0,
                                                 err: 1'b0});
          ROW_LAST:    awaited_words.push_back('{data: in_byte, first: 1'b0, last: 1'b1,
                                                 err: 1'b0});
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{data: out_byte, first: frame_first, last: frame_last,
                err: overlength_error};
        if (awaited_words.size() == 0) begin
          flag_mismatch("unexpected word", '0, got);
        end else begin
          want = awaited_words.pop_front();
          if (got !== want) flag_mismatch("word mismatch", want, got);
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // present one byte, hold it until taken
  task automatic send_byte(input row_kind_e kind, input logic [BYTE_W-1:0] b);
    row_checks.push_back(kind);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // caller lowers cfg_valid after the last write of a batch
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop input and wait for every awaited word plus a quiet stretch
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // one random stretch of the stream, mostly well-formed frames
  task automatic emit_sequence(output int count);
    logic [BYTE_W-1:0] stream_q [$];
    int pick;
    int span;
    int eff;
    int body;
    pick = $urandom_range(0, 9);
    if (pick <= 6) begin
      stream_q = '{sync_pat[0], sync_pat[1], sync_pat[2]};
      repeat (LEN_LO_POS - 3) stream_q.push_back(BYTE_W'($urandom));
      if (pick <= 5) begin
        // frame with a short message body, usually within the limit
        eff = (hdr_len < HOLD_BYTES) ? HOLD_BYTES : int'(hdr_len);
        span = $urandom_range(0, 6);
        stream_q.push_back(BYTE_W'(span));
        stream_q.push_back(8'h00);
        body = eff + span + CRC_BYTES - HOLD_BYTES;
        // header over the limit is dropped, a few trailing bytes will do
        if (eff + span > int'(len_limit)) body = $urandom_range(0, 4);
        repeat (body)
          stream_q.push_back(BYTE_W'($urandom));
      end else if ($urandom_range(0, 3) == 0) begin
        stream_q.push_back(8'hFF);
        stream_q.push_back(8'hFF);
      end else begin
        // length far over any limit
        stream_q.push_back(BYTE_W'($urandom));
        stream_q.push_back(BYTE_W'($urandom_range(64, 255)));
      end
    end else if (pick == 7) begin
      // broken sync pattern
      stream_q.push_back(sync_pat[0]);
      if ($urandom_range(0, 1) == 1) stream_q.push_back(sync_pat[1]);
      repeat ($urandom_range(1, 3)) stream_q.push_back(BYTE_W'($urandom));
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 4)) stream_q.push_back(BYTE_W'($urandom));
    end else begin
      repeat (HOLD_BYTES) stream_q.push_back(BYTE_W'($urandom));
    end
    foreach (stream_q[i]) send_byte(ROW_PREDICT, stream_q[i]);
    count = stream_q.size();
  endtask

  // new register setting and idling mix, then random stream
  task automatic run_phase(input logic [BYTE_W-1:0] s1, input logic [BYTE_W-1:0] s2,
                           input logic [BYTE_W-1:0] s3, input logic [BYTE_W-1:0] hl,
                           input logic [LIMIT_W-1:0] lim, input int send_pct,
                           input int recv_pct);
    logic [CFG_DATA_W-1:0] pad;
    int sent;
    int got;
    settle_block();
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    pad = CFG_DATA_W'($urandom);
    // spare high bits of the data bus must be dropped
    write_register(REG_SYNC_FIRST, {pad[CFG_DATA_W-1:BYTE_W], s1});
    write_register(REG_SYNC_SECOND, {~pad[CFG_DATA_W-1:BYTE_W], s2});
    write_register(REG_SYNC_THIRD, {pad[CFG_DATA_W-1:BYTE_W], s3});
    write_register(REG_HEADER_LENGTH, {~pad[CFG_DATA_W-1:BYTE_W], hl});
    write_register(REG_LENGTH_LIMIT, CFG_DATA_W'(lim));
    write_register(REG_NONE, pad);
    cfg_valid <= 1'b0;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      emit_sequence(got);
      sent += got;
    end
  endtask

  initial begin : stimulus
    bit prev_cfg;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_byte   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SYNC_FIRST;
    cfg_data  = '0;
    // shadow state after reset
    foreach (hold_copy[i]) hold_copy[i] = '0;
    held_n      = 0;
    frame_left  = 0;
    framing     = 1'b0;
    sync_pat[0] = SYNC_FIRST_RST;
    sync_pat[1] = SYNC_SECOND_RST;
    sync_pat[2] = SYNC_THIRD_RST;
    hdr_len     = HEADER_LENGTH_RST;
    len_limit   = LENGTH_LIMIT_RST;

    // short header length, tightest limit, then hunting, an error and a frame
    directed_rows = '{
      '{ROW_CFG,     8'h00, REG_HEADER_LENGTH, 14'd0},
      '{ROW_CFG,     8'h00, REG_LENGTH_LIMIT,  14'd10},
      '{ROW_QUIET,   8'hFF, REG_NONE, '0},
      '{ROW_QUIET,   8'h00, REG_NONE, '0},
      '{ROW_QUIET,   8'hAA, REG_NONE, '0},
      '{ROW_QUIET,   8'h44, REG_NONE, '0},
      '{ROW_QUIET,   8'h12, REG_NONE, '0},
      '{ROW_QUIET,   8'h00, REG_NONE, '0},
      '{ROW_QUIET,   8'hAA, REG_NONE, '0},
      '{ROW_QUIET,   8'h44, REG_NONE, '0},
      '{ROW_QUIET,   8'h12, REG_NONE, '0},
      '{ROW_QUIET,   8'h00, REG_NONE, '0},
      '{ROW_QUIET,   8'h01, REG_NONE, '0},
      '{ROW_ERROR,   8'h00, REG_NONE, '0},
      '{ROW_QUIET,   8'hFF, REG_NONE, '0},
      '{ROW_QUIET,   8'hFF, REG_NONE, '0},
      '{ROW_QUIET,   8'h00, REG_NONE, '0},
      '{ROW_PREDICT, 8'h00, REG_NONE, '0},
      '{ROW_FWD,     8'h5A, REG_NONE, '0},
      '{ROW_FWD,     8'hA5, REG_NONE, '0},
      '{ROW_FWD,     8'hFF, REG_NONE, '0},
      '{ROW_LAST,    8'h00, REG_NONE, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows
    prev_cfg = 1'b0;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        if (!prev_cfg) settle_block();
        write_register(directed_rows[r].index, directed_rows[r].data);
        prev_cfg = 1'b1;
      end else begin
        cfg_valid <= 1'b0;
        send_byte(directed_rows[r].kind, directed_rows[r].value);
        prev_cfg = 1'b0;
      end
    end

    // random phases: no idling, sender idle, receiver stall, both
    run_phase(8'hFF, 8'h00, 8'hFF, 8'd10, 14'd16383, 0, 0);
    run_phase(SYNC_FIRST_RST, SYNC_SECOND_RST, SYNC_THIRD_RST, HEADER_LENGTH_RST,
              LENGTH_LIMIT_RST, 62, 0);
    run_phase(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), 8'd9, 14'd24,
              0, 62);
    run_phase(8'h00, 8'h00, 8'h00, 8'd255, 14'd254, 34, 34);
    run_phase(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), 8'd12, 14'd30,
              34, 34);

    settle_block();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
